// ===== design/dsmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Display sleep and mode controller package
// Shared types, register indexes, operation codes and timing constants.
// ----------------------------------------------------------------------------
package dsmc_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;
   localparam int MinuteWidth   = 11;
   localparam int RotateMsWidth = 26;

   typedef logic [CsrIndexWidth-1:0] csr_index_type;
   typedef logic [CsrDataWidth-1:0]  csr_data_type;
   typedef logic [MinuteWidth-1:0]   minute_type;

   localparam csr_index_type CSR_SCHEDULE_ENABLE = 3'd0;
   localparam csr_index_type CSR_OFF_HOUR        = 3'd1;
   localparam csr_index_type CSR_OFF_MINUTE      = 3'd2;
   localparam csr_index_type CSR_ON_HOUR         = 3'd3;
   localparam csr_index_type CSR_ON_MINUTE       = 3'd4;
   localparam csr_index_type CSR_ROTATE_ENABLE   = 3'd5;
   localparam csr_index_type CSR_ROTATE_SECONDS  = 3'd6;
   localparam csr_index_type CSR_CONTRAST_LEVEL  = 3'd7;

   localparam logic [1:0] OP_TOUCH    = 2'd0;
   localparam logic [1:0] OP_TICK     = 2'd1;
   localparam logic [1:0] OP_OVERRIDE = 2'd2;

   localparam logic [1:0] OVR_AUTO     = 2'd0;
   localparam logic [1:0] OVR_ON       = 2'd1;
   localparam logic [1:0] OVR_OFF      = 2'd2;
   localparam logic [1:0] OVR_RESERVED = 2'd3;

   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_ON   = 2'd1;
   localparam logic [1:0] CMD_OFF  = 2'd2;

   localparam logic [31:0] DEBOUNCE_MS = 32'd60;
   localparam logic [31:0] PEEK_MS     = 32'd20000;
   localparam logic [31:0] RENDER_MS   = 32'd200;
   localparam logic [RotateMsWidth-1:0] MS_PER_SEC = 26'd1000;
   localparam minute_type  MIN_PER_HOUR = 11'd60;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now_ms;
      logic        touch_level;
      logic        time_synced;
      logic [4:0]  clock_hour;
      logic [5:0]  clock_minute;
      logic [1:0]  override_value;
   } req_type;

   typedef struct packed {
      logic        panel_awake;
      logic [2:0]  display_mode;
      logic [1:0]  panel_command;
      logic        contrast_write;
      logic [7:0]  contrast_value;
      logic        render_due;
   } rsp_type;

   typedef struct packed {
      logic                     schedule_enable;
      logic [4:0]               off_hour;
      logic [5:0]               off_minute;
      logic [4:0]               on_hour;
      logic [5:0]               on_minute;
      logic                     rotate_enable;
      logic [RotateMsWidth-1:0] rotate_ms;
      logic [7:0]               contrast_level;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  override_state;
      logic        peek_active;
      logic [31:0] peek_expiry;
      logic [2:0]  mode_index;
      logic [31:0] last_mode_change;
      logic [31:0] last_render;
      logic        powered_on;
      logic        touch_level_seen;
      logic [31:0] last_touch_edge;
   } state_type;

   function automatic minute_type minute_of_day(logic [4:0] hour, logic [5:0] minute);
      return minute_type'(hour) * MIN_PER_HOUR + minute_type'(minute);
   endfunction

endpackage

// ===== design/dsmc_if.sv =====
// ----------------------------------------------------------------------------
// Display sleep and mode controller channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface dsmc_req_if;
   import dsmc_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dsmc_rsp_if;
   import dsmc_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/display_sleep_and_mode_controller_core.sv =====
// ----------------------------------------------------------------------------
// Display sleep and mode controller core
// Debounces touch, tracks panel power, the nightly off window, peeks and
// display mode rotation, and issues panel commands and render requests.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake      Content
//   req_ch    in          valid/ready    operation, time, touch, clock, override
//   rsp_ch    out         valid/ready    power, mode, command, contrast, render
//   csr_*     in          write enable   eight configuration registers
//
// One item per cycle is accepted while the response is not stalled; each result is
// presented once it has passed the input register into the result register.
// All state is updated in the single compute stage between those registers.
// A stalled response holds the pipeline; the input register still takes one item.
// Reset is synchronous and restores the register and state defaults.
module display_sleep_and_mode_controller_core #(
   parameter int NUM_MODES = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  dsmc_pkg::csr_index_type csr_index,
   input  dsmc_pkg::csr_data_type  csr_wdata,
   dsmc_req_if.sink               req_ch,
   dsmc_rsp_if.source             rsp_ch
);
   import dsmc_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   req_type   item_ff;
   logic      item_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SCHEDULE_ENABLE: cfg_in.schedule_enable = csr_wdata[0];
            CSR_OFF_HOUR:        cfg_in.off_hour        = csr_wdata[4:0];
            CSR_OFF_MINUTE:      cfg_in.off_minute      = csr_wdata[5:0];
            CSR_ON_HOUR:         cfg_in.on_hour         = csr_wdata[4:0];
            CSR_ON_MINUTE:       cfg_in.on_minute       = csr_wdata[5:0];
            CSR_ROTATE_ENABLE:   cfg_in.rotate_enable   = csr_wdata[0];
            CSR_ROTATE_SECONDS:  cfg_in.rotate_ms       = RotateMsWidth'(csr_wdata) * MS_PER_SEC;
            CSR_CONTRAST_LEVEL:  cfg_in.contrast_level  = csr_wdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.schedule_enable <= 1'b0;
         cfg_ff.off_hour        <= 5'd23;
         cfg_ff.off_minute      <= 6'd0;
         cfg_ff.on_hour         <= 5'd7;
         cfg_ff.on_minute       <= 6'd0;
         cfg_ff.rotate_enable   <= 1'b0;
         cfg_ff.rotate_ms       <= 26'd10000;
         cfg_ff.contrast_level  <= 8'd255;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !item_valid_ff || advance;

   dsmc_engine #(
      .NUM_MODES (NUM_MODES)
   ) u_engine (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff <= req_ch.payload;
      end
      if (advance && item_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff.override_state   <= OVR_AUTO;
         state_ff.peek_active      <= 1'b0;
         state_ff.peek_expiry      <= 32'd0;
         state_ff.mode_index       <= 3'd0;
         state_ff.last_mode_change <= 32'd0;
         state_ff.last_render      <= 32'd0;
         state_ff.powered_on       <= 1'b1;
         state_ff.touch_level_seen <= 1'b0;
         state_ff.last_touch_edge  <= 32'd0;
      end else begin
         if (req_ch.ready) begin
            item_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= item_valid_ff;
            if (item_valid_ff) begin
               state_ff <= state_in;
            end
         end
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

endmodule

// ===== design/dsmc_engine.sv =====
// ----------------------------------------------------------------------------
// Display sleep and mode controller engine
// Computes the next controller state and the response for one request item.
// ----------------------------------------------------------------------------
module dsmc_engine #(
   parameter int NUM_MODES = 6
) (
   input  dsmc_pkg::cfg_type   cfg,
   input  dsmc_pkg::state_type state_cur,
   input  dsmc_pkg::req_type   item,
   output dsmc_pkg::state_type state_nxt,
   output dsmc_pkg::rsp_type   rsp
);
   import dsmc_pkg::*;

   localparam logic [3:0] ModeCount = 4'(NUM_MODES);

   minute_type cur_min;
   minute_type off_min;
   minute_type on_min;
   logic       in_window;
   logic       awake;
   logic       peek_expire;
   logic       touch_take;
   logic       rotate_due;
   logic [3:0] mode_inc;
   logic [2:0] mode_next;

   always_comb begin
      cur_min = minute_of_day(item.clock_hour, item.clock_minute);
      off_min = minute_of_day(cfg.off_hour, cfg.off_minute);
      on_min  = minute_of_day(cfg.on_hour, cfg.on_minute);
      if (off_min == on_min) begin
         in_window = 1'b0;
      end else if (off_min < on_min) begin
         in_window = (cur_min >= off_min) && (cur_min < on_min);
      end else begin
         in_window = (cur_min >= off_min) || (cur_min < on_min);
      end
   end

   always_comb begin
      peek_expire = 1'b0;
      if (state_cur.override_state == OVR_ON) begin
         awake = 1'b1;
      end else if (state_cur.override_state == OVR_OFF) begin
         awake = 1'b0;
      end else if (!cfg.schedule_enable || !item.time_synced) begin
         awake = 1'b1;
      end else if (state_cur.peek_active && (item.now_ms < state_cur.peek_expiry)) begin
         awake = 1'b1;
      end else begin
         peek_expire = state_cur.peek_active;
         awake       = !in_window;
      end
   end

   assign mode_inc  = {1'b0, state_cur.mode_index} + 4'd1;
   assign mode_next = (mode_inc == ModeCount) ? 3'd0 : mode_inc[2:0];

   assign touch_take = (item.touch_level != state_cur.touch_level_seen) &&
                       ((item.now_ms - state_cur.last_touch_edge) > DEBOUNCE_MS);
   assign rotate_due = cfg.rotate_enable &&
                       ((item.now_ms - state_cur.last_mode_change) > 32'(cfg.rotate_ms));

   always_comb begin
      state_nxt          = state_cur;
      rsp.panel_command  = CMD_NONE;
      rsp.contrast_write = 1'b0;
      rsp.contrast_value = 8'd0;
      rsp.render_due     = 1'b0;
      case (item.operation)
         OP_TOUCH: begin
            if (touch_take) begin
               state_nxt.last_touch_edge  = item.now_ms;
               state_nxt.touch_level_seen = item.touch_level;
               if (item.touch_level) begin
                  if (peek_expire) begin
                     state_nxt.peek_active = 1'b0;
                  end
                  if (!awake) begin
                     state_nxt.override_state = OVR_AUTO;
                     if (cfg.schedule_enable && item.time_synced && in_window) begin
                        state_nxt.peek_active = 1'b1;
                        state_nxt.peek_expiry = item.now_ms + PEEK_MS;
                     end
                  end else begin
                     state_nxt.mode_index       = mode_next;
                     state_nxt.last_mode_change = item.now_ms;
                  end
               end
            end
         end
         OP_TICK: begin
            if (peek_expire) begin
               state_nxt.peek_active = 1'b0;
            end
            if (awake != state_cur.powered_on) begin
               state_nxt.powered_on = awake;
               if (awake) begin
                  rsp.panel_command  = CMD_ON;
                  rsp.contrast_write = 1'b1;
                  rsp.contrast_value = cfg.contrast_level;
               end else begin
                  rsp.panel_command = CMD_OFF;
               end
            end
            if (awake) begin
               if (rotate_due) begin
                  state_nxt.mode_index       = mode_next;
                  state_nxt.last_mode_change = item.now_ms;
               end
               if ((item.now_ms - state_cur.last_render) >= RENDER_MS) begin
                  state_nxt.last_render = item.now_ms;
                  rsp.render_due        = 1'b1;
               end
            end
         end
         OP_OVERRIDE: begin
            state_nxt.override_state = (item.override_value == OVR_RESERVED) ? OVR_AUTO
                                                                           : item.override_value;
            state_nxt.peek_active    = 1'b0;
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
      rsp.panel_awake  = state_nxt.powered_on;
      rsp.display_mode = state_nxt.mode_index;
   end

endmodule

// ===== design/dsmc_checker.sv =====
// ----------------------------------------------------------------------------
// Display sleep and mode controller checker
// Port-level assertions on the response channel, bound to the core.
// ----------------------------------------------------------------------------
module dsmc_checker #(
   parameter int NUM_MODES = 6
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dsmc_pkg::rsp_type rsp_payload
);
   import dsmc_pkg::*;

   localparam logic [3:0] ModeCount = 4'(NUM_MODES);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled response changed before its transfer.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_payload.display_mode} < ModeCount))
      else $error("Display mode is outside the mode count.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.panel_command == CMD_ON) |-> rsp_payload.panel_awake &&
      rsp_payload.contrast_write)
      else $error("Display on command without an awake panel and contrast write.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.panel_command == CMD_OFF) |-> !rsp_payload.panel_awake &&
      !rsp_payload.render_due)
      else $error("Display off command with an awake panel or a render.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.contrast_write |-> (rsp_payload.contrast_value == 8'd0))
      else $error("Contrast value present without a contrast write.");

endmodule

bind display_sleep_and_mode_controller_core dsmc_checker #(
   .NUM_MODES (NUM_MODES)
) u_dsmc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);
